// ===== sv/dfrp_pkg.sv =====
// Shared types, register indexes and reset values for the font register port.
package dfrp_pkg;

    // Access kinds carried in the request's tuser bit.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Register indexes.
    localparam logic [7:0] IDX_MODE_ONE     = 8'hb9;
    localparam logic [7:0] IDX_MODE_TWO     = 8'hba;
    localparam logic [7:0] IDX_ANK_GROUP    = 8'hbb;
    localparam logic [7:0] IDX_CODE_FIRST   = 8'hbc;
    localparam logic [7:0] IDX_CODE_SECOND  = 8'hbd;
    localparam logic [7:0] IDX_FONT_DATA    = 8'hbe;
    localparam logic [7:0] IDX_STATUS       = 8'hbf;
    localparam logic [7:0] IDX_UPPER_START  = 8'hd9;
    localparam logic [7:0] IDX_LOWER_START  = 8'hda;
    localparam logic [7:0] IDX_START_LINE   = 8'hdb;
    localparam logic [7:0] IDX_SUPERIMPOSE  = 8'hdc;
    localparam logic [7:0] IDX_CURSOR_MODE  = 8'hdd;
    localparam logic [7:0] IDX_CURSOR_SKEW  = 8'hde;
    localparam logic [7:0] IDX_SPARE        = 8'hdf;

    // Reset values of the byte registers, and the fixed value read from the status index.
    localparam logic [7:0] RST_MODE_ONE    = 8'hc8;
    localparam logic [7:0] RST_START_LINE  = 8'h01;
    localparam logic [7:0] RST_UPPER_START = 8'h03;
    localparam logic [7:0] RST_CURSOR_SKEW = 8'h20;
    localparam logic [7:0] STATUS_READ     = 8'h03;

    // Glyph geometry in rows.
    localparam logic [5:0] WIDE_ROWS   = 6'd32;
    localparam logic [5:0] NARROW_ROWS = 6'd19;

    // One accepted bus access as it leaves the input register.
    typedef struct packed {
        logic       valid;
        logic       wr;
        logic [7:0] index;
        logic [7:0] data;
    } cmd_t;

    // A first code byte in these ranges selects a double-byte glyph.
    function automatic logic is_wide(input logic [7:0] c);
        return (c >= 8'h40 && c <= 8'h7e) || (c >= 8'h80 && c <= 8'hfc);
    endfunction

endpackage

// ===== sv/dfrp_ram.sv =====
// Generic single-port RAM with registered read data.
module dfrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read data holds until the next read.
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/dfrp_font.sv =====
// Code byte registers, row counter and the two glyph stores.
module dfrp_font #(
    parameter int WIDE_CODE_BITS = 16,
    parameter int NARROW_CODES   = 256
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  dfrp_pkg::cmd_t cmd,
    output logic [7:0]    code_first,
    output logic [7:0]    code_second,
    output logic [7:0]    glyph_data
);

    import dfrp_pkg::*;

    localparam int WIDE_DEPTH   = (1 << WIDE_CODE_BITS) * 32;
    localparam int WIDE_AW      = WIDE_CODE_BITS + 5;
    localparam int NARROW_DEPTH = NARROW_CODES * 19;
    localparam int NARROW_AW    = $clog2(NARROW_DEPTH);

    // First code byte reduced modulo the number of single-byte glyphs.
    function automatic logic [255:0][7:0] build_mod();
        logic [255:0][7:0] t;
        for (int i = 0; i < 256; i++) begin
            t[i] = 8'(i % NARROW_CODES);
        end
        return t;
    endfunction

    localparam logic [255:0][7:0] NarrowMod = build_mod();

    logic [7:0] code_first_reg, code_first_next;
    logic [7:0] code_second_reg, code_second_next;
    logic [5:0] row_reg, row_next;
    logic       wide_sel_reg, wide_sel_next;

    logic                 wide;
    logic [5:0]           row_eff;
    logic [15:0]          code_full;
    logic [WIDE_AW-1:0]   wide_addr;
    logic [NARROW_AW-1:0] narrow_addr;
    logic                 font_go;
    logic [7:0]           wide_q;
    logic [7:0]           narrow_q;

    assign wide      = is_wide(code_first_reg);
    assign code_full = {code_first_reg, code_second_reg};
    assign font_go   = cmd.valid && (cmd.index == IDX_FONT_DATA);

    always_comb begin
        if (wide) begin
            row_eff = (row_reg >= WIDE_ROWS) ? 6'd0 : row_reg;
        end else begin
            row_eff = (row_reg >= NARROW_ROWS) ? 6'd0 : row_reg;
        end
    end

    // Left-half rows sit on even bytes, right-half rows on odd bytes.
    assign wide_addr = {code_full[WIDE_CODE_BITS-1:0], row_eff[3:0], row_eff[4]};
    assign narrow_addr = NARROW_AW'(NARROW_AW'(NarrowMod[code_first_reg])
                                    * NARROW_AW'(NARROW_ROWS)
                                    + NARROW_AW'(row_eff));

    always_comb begin
        code_first_next  = code_first_reg;
        code_second_next = code_second_reg;
        row_next         = row_reg;
        wide_sel_next    = wide_sel_reg;
        if (cmd.valid) begin
            unique case (cmd.index)
                IDX_CODE_FIRST: begin
                    if (cmd.wr && (cmd.data != code_first_reg)) begin
                        code_first_next = cmd.data;
                        row_next        = 6'd0;
                    end
                end
                IDX_CODE_SECOND: begin
                    if (cmd.wr && (cmd.data != code_second_reg)) begin
                        code_second_next = cmd.data;
                        row_next         = 6'd0;
                    end
                end
                IDX_FONT_DATA: begin
                    row_next      = row_eff + 6'd1;
                    wide_sel_next = wide;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_first_reg  <= 8'd0;
            code_second_reg <= 8'd0;
            row_reg         <= 6'd0;
            wide_sel_reg    <= 1'b0;
        end else begin
            code_first_reg  <= code_first_next;
            code_second_reg <= code_second_next;
            row_reg         <= row_next;
            wide_sel_reg    <= wide_sel_next;
        end
    end

    dfrp_ram #(
        .WIDTH (8),
        .DEPTH (WIDE_DEPTH)
    ) u_wide_ram (
        .aclk  (aclk),
        .en    (font_go && wide),
        .we    (cmd.wr),
        .addr  (wide_addr),
        .wdata (cmd.data),
        .rdata (wide_q)
    );

    dfrp_ram #(
        .WIDTH (8),
        .DEPTH (NARROW_DEPTH)
    ) u_narrow_ram (
        .aclk  (aclk),
        .en    (font_go && !wide),
        .we    (cmd.wr),
        .addr  (narrow_addr),
        .wdata (cmd.data),
        .rdata (narrow_q)
    );

    assign code_first  = code_first_reg;
    assign code_second = code_second_reg;
    assign glyph_data  = wide_sel_reg ? wide_q : narrow_q;

    // The counter can reach the wide wrap point but never pass it.
    a_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg <= WIDE_ROWS)
        else $error("row counter beyond glyph height");

    // A changed first code byte always restarts the glyph at row zero.
    a_code_clears_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.valid && cmd.wr && cmd.index == IDX_CODE_FIRST
         && cmd.data != code_first_reg) |=> row_reg == 6'd0)
        else $error("row counter not cleared on code change");

endmodule

// ===== sv/dbcs_font_register_port.sv =====
// Top level of the indexed register port with font access.
//
// Requests arrive on the s_ channel: tuser carries the access kind (0 read,
// 1 write), tdata carries the register index and the write byte. Every
// request gives exactly one result on the m_ channel: tdata is the byte read
// (zero for a write) and tuser flags an unknown register index.
//
// A request passes an input register, where the byte registers are updated
// and the glyph store is addressed, then waits in the wait stage for the
// registered store read, and lands in the output register. A new request is
// not taken while one sits in the input register; it can be taken while the
// last one waits in the wait stage, if that one can move to the output register.
//
// A request is taken while a finished result still waits in the output
// register; tready drops while the input register holds a request, or while
// the wait stage is full and the output register is not free. Reset restores
// the byte registers to their documented values and clears the code bytes
// and row counter. Glyph memory contents are undefined until written.
module dbcs_font_register_port #(
    parameter int WIDE_CODE_BITS = 16,
    parameter int NARROW_CODES   = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] reg_index, [15:8] write_data
    input  logic        s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] read_data
    output logic        m_tuser    // [0] bad_index
);

    import dfrp_pkg::*;

    // Input register.
    logic       a_valid_reg;
    logic       a_wr_reg;
    logic [7:0] a_index_reg;
    logic [7:0] a_data_reg;

    // Wait stage for the store read.
    logic       b_valid_reg;
    logic       b_wr_reg;
    logic       b_font_reg;
    logic       b_bad_reg;
    logic [7:0] b_data_reg;

    // Output register.
    logic       m_valid_reg;
    logic [7:0] m_data_reg;
    logic       m_bad_reg;

    // Byte registers.
    logic [7:0] mode_one_reg, mode_two_reg, ank_group_reg;
    logic [7:0] upper_start_reg, lower_start_reg, start_line_reg;
    logic [7:0] superimpose_reg, cursor_mode_reg, cursor_skew_reg, spare_reg;

    logic       out_free;
    logic       b_move;
    logic       s_take;
    cmd_t       cmd;
    logic [7:0] code_first;
    logic [7:0] code_second;
    logic [7:0] glyph_data;
    logic [7:0] rd_val;
    logic       bad;
    logic       font;

    assign out_free = !m_valid_reg || m_tready;
    assign b_move   = b_valid_reg && out_free;
    assign s_tready = !a_valid_reg && (!b_valid_reg || out_free);
    assign s_take   = s_tvalid && s_tready;

    assign cmd = '{valid: a_valid_reg, wr: a_wr_reg, index: a_index_reg, data: a_data_reg};

    always_comb begin
        rd_val = 8'd0;
        bad    = 1'b0;
        font   = 1'b0;
        unique case (a_index_reg)
            IDX_MODE_ONE:    rd_val = mode_one_reg;
            IDX_MODE_TWO:    rd_val = mode_two_reg;
            IDX_ANK_GROUP:   rd_val = ank_group_reg;
            IDX_CODE_FIRST:  rd_val = code_first;
            IDX_CODE_SECOND: rd_val = code_second;
            IDX_FONT_DATA:   font   = 1'b1;
            IDX_STATUS:      rd_val = STATUS_READ;
            IDX_UPPER_START: rd_val = upper_start_reg;
            IDX_LOWER_START: rd_val = lower_start_reg;
            IDX_START_LINE:  rd_val = start_line_reg;
            IDX_SUPERIMPOSE: rd_val = superimpose_reg;
            IDX_CURSOR_MODE: rd_val = cursor_mode_reg;
            IDX_CURSOR_SKEW: rd_val = cursor_skew_reg;
            IDX_SPARE:       rd_val = spare_reg;
            default:         bad    = 1'b1;
        endcase
    end

    dfrp_font #(
        .WIDE_CODE_BITS (WIDE_CODE_BITS),
        .NARROW_CODES   (NARROW_CODES)
    ) u_font (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .code_first  (code_first),
        .code_second (code_second),
        .glyph_data  (glyph_data)
    );

    // Control state of the three stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= s_take;
            if (a_valid_reg) begin
                b_valid_reg <= 1'b1;
            end else if (b_move) begin
                b_valid_reg <= 1'b0;
            end
            if (b_move) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_take) begin
            a_wr_reg    <= s_tuser;
            a_index_reg <= s_tdata[7:0];
            a_data_reg  <= s_tdata[15:8];
        end
        if (a_valid_reg) begin
            b_wr_reg   <= a_wr_reg;
            b_font_reg <= font;
            b_bad_reg  <= bad;
            b_data_reg <= rd_val;
        end
        if (b_move) begin
            m_bad_reg <= b_bad_reg;
            if (b_wr_reg == OP_WRITE) begin
                m_data_reg <= 8'd0;
            end else begin
                m_data_reg <= b_font_reg ? glyph_data : b_data_reg;
            end
        end
    end

    // Byte register file.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_one_reg    <= RST_MODE_ONE;
            mode_two_reg    <= 8'd0;
            ank_group_reg   <= 8'd0;
            upper_start_reg <= RST_UPPER_START;
            lower_start_reg <= 8'd0;
            start_line_reg  <= RST_START_LINE;
            superimpose_reg <= 8'd0;
            cursor_mode_reg <= 8'd0;
            cursor_skew_reg <= RST_CURSOR_SKEW;
            spare_reg       <= 8'd0;
        end else if (a_valid_reg && a_wr_reg == OP_WRITE) begin
            unique case (a_index_reg)
                IDX_MODE_ONE:    mode_one_reg    <= a_data_reg;
                IDX_MODE_TWO:    mode_two_reg    <= a_data_reg;
                IDX_ANK_GROUP:   ank_group_reg   <= a_data_reg;
                IDX_UPPER_START: upper_start_reg <= a_data_reg;
                IDX_LOWER_START: lower_start_reg <= a_data_reg;
                IDX_START_LINE:  start_line_reg  <= a_data_reg;
                IDX_SUPERIMPOSE: superimpose_reg <= a_data_reg;
                IDX_CURSOR_MODE: cursor_mode_reg <= a_data_reg;
                IDX_CURSOR_SKEW: cursor_skew_reg <= a_data_reg;
                IDX_SPARE:       spare_reg       <= a_data_reg;
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_bad_reg;

    // Only one request is ever between the input register and the wait stage.
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(a_valid_reg && b_valid_reg))
        else $error("two requests in flight");

    // The input register always drains into the wait stage in the next cycle.
    a_a_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg |=> b_valid_reg && !a_valid_reg)
        else $error("input register did not drain");

    // An unknown index reads as zero.
    a_bad_reads_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_bad_reg) |-> m_data_reg == 8'd0)
        else $error("unknown index returned data");

    // A waiting request leaves the wait stage as soon as the output is free.
    a_b_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && out_free) |=> m_valid_reg)
        else $error("result lost between stages");

endmodule
